@@ design/nearest_live_node_search_macros.svh @@
// Assertion macros for the nearest live node search block.
// Used by the port checker; no other dependencies.
`ifndef NEAREST_LIVE_NODE_SEARCH_MACROS_SVH
`define NEAREST_LIVE_NODE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NLNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NLNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/nlns_pkg.sv @@
// Shared constants, types and beat layouts for the nearest live node search.
// No dependencies; imported by every module of the block.
`default_nettype none

package nlns_pkg;

    localparam int MAX_NODES  = 4096;
    localparam int IDX_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int COORD_BITS = 11;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int RAD_BITS   = 8;
    localparam int R2_BITS    = 2 * RAD_BITS;

    // Fixed field widths of the stream beats
    localparam int ENTRY_BITS = 12;
    localparam int POS_BITS   = 11;

    // Slave tdata layout, lowest bit first
    localparam int S_IDX_LSB    = 0;
    localparam int S_X_LSB      = S_IDX_LSB + ENTRY_BITS;
    localparam int S_Y_LSB      = S_X_LSB + POS_BITS;
    localparam int S_ALIVE_BIT  = S_Y_LSB + POS_BITS;
    localparam int S_USED_BITS  = S_ALIVE_BIT + 1;
    localparam int S_TDATA_BITS = ((S_USED_BITS + 7) / 8) * 8;

    // Master tdata layout, lowest bit first
    localparam int M_IDX_LSB    = 0;
    localparam int M_FOUND_BIT  = M_IDX_LSB + ENTRY_BITS;
    localparam int M_INSIDE_BIT = M_FOUND_BIT + 1;
    localparam int M_DIST_LSB   = M_INSIDE_BIT + 1;
    localparam int M_DIST_MSB   = M_DIST_LSB + DIST_BITS - 1;
    localparam int M_USED_BITS  = M_DIST_MSB + 1;
    localparam int M_TDATA_BITS = ((M_USED_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_TDATA_BITS - M_USED_BITS;

    localparam logic [RAD_BITS-1:0] RADIUS_RST = RAD_BITS'(10);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                  alive;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_node;

    // One table read heading into the distance unit
    typedef struct packed {
        logic                vld;
        logic [IDX_BITS-1:0] idx;
        t_node               node;
    } t_scan;

    // Running best match
    typedef struct packed {
        logic                 found;
        logic [IDX_BITS-1:0]  idx;
        logic [DIST_BITS-1:0] dist_sq;
    } t_best;

endpackage

`default_nettype wire

@@ design/nlns_node_mem.sv @@
// Node table: one write port, one read port with registered read data.
// Depends on nlns_pkg for depth and entry layout.
`default_nettype none

module nlns_node_mem
    import nlns_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [IDX_BITS-1:0] i_waddr,
    input  wire t_node               i_wdata,
    input  wire logic [IDX_BITS-1:0] i_raddr,
    output t_node                    o_rdata
);

    t_node r_mem [MAX_NODES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/nlns_dist_unit.sv @@
// Shared distance unit: abs diff, square, then sum and compare against the best.
// Depends on nlns_pkg for t_scan and t_best.
`default_nettype none

module nlns_dist_unit
    import nlns_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_scan                 i_scan,
    input  wire logic [COORD_BITS-1:0] i_qx,
    input  wire logic [COORD_BITS-1:0] i_qy,
    output t_best                      o_best,
    output logic                       o_busy
);

    // stage 1: absolute differences
    logic                  r_s1_vld;
    logic                  r_s1_alive;
    logic [IDX_BITS-1:0]   r_s1_idx;
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic [COORD_BITS-1:0] n_dx;
    logic [COORD_BITS-1:0] n_dy;

    // stage 2: squares
    logic                  r_s2_vld;
    logic                  r_s2_alive;
    logic [IDX_BITS-1:0]   r_s2_idx;
    logic [SQ_BITS-1:0]    r_sqx;
    logic [SQ_BITS-1:0]    r_sqy;

    // stage 3: sum, compare, keep best
    logic [DIST_BITS-1:0]  n_sum;
    logic                  n_take;
    t_best                 r_best;

    always_comb begin
        n_dx = (i_qx > i_scan.node.x) ? (i_qx - i_scan.node.x) : (i_scan.node.x - i_qx);
        n_dy = (i_qy > i_scan.node.y) ? (i_qy - i_scan.node.y) : (i_scan.node.y - i_qy);
        n_sum = DIST_BITS'(r_sqx) + DIST_BITS'(r_sqy);
        // strict less-than keeps the lowest index on a tie
        n_take = r_s2_vld && r_s2_alive && (!r_best.found || (n_sum < r_best.dist_sq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_best   <= '0;
        end else begin
            r_s1_vld <= i_scan.vld;
            r_s2_vld <= r_s1_vld;
            if (i_start) begin
                r_best <= '0;
            end else if (n_take) begin
                r_best.found   <= 1'b1;
                r_best.idx     <= r_s2_idx;
                r_best.dist_sq <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_alive <= i_scan.node.alive;
        r_s1_idx   <= i_scan.idx;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_s2_alive <= r_s1_alive;
        r_s2_idx   <= r_s1_idx;
        r_sqx      <= SQ_BITS'(r_dx) * SQ_BITS'(r_dx);
        r_sqy      <= SQ_BITS'(r_dy) * SQ_BITS'(r_dy);
    end

    assign o_best = r_best;
    assign o_busy = r_s1_vld || r_s2_vld;

endmodule

`default_nettype wire

@@ design/nearest_live_node_search.sv @@
// Top level of the nearest live node search: sequencer, table, distance unit.
// Depends on nlns_pkg, nlns_node_mem and nlns_dist_unit.
//
//  port group    dir  role                   payload, lowest bit first
//  s_axis_*      in   write / query beats    tuser: opcode
//                                            tdata: entry_index, pos_x, pos_y, alive_in
//  m_axis_*      out  one beat per query     tdata: nearest_index, found,
//                                            inside_dead_zone, nearest_dist_sq
//  i_cfg_*       in   dead_zone_radius       i_cfg_wdata, taken when i_cfg_we is high
//
// After a write beat, s_axis_tready stays high for the next beat.
// A query holds s_axis_tready low while the table is read one entry per cycle
// through the single read port into a three-stage shared distance unit, and
// while the pipeline drains.
// After reset the table is swept to zero with s_axis_tready low.
// A finished result sits in the output register; the block takes new beats
// while it waits, and a later query holds its result until that register frees.
`default_nettype none

module nearest_live_node_search
    import nlns_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input beats
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,   // entry_index, pos_x, pos_y, alive_in
    input  wire logic [0:0]              s_axis_tuser,   // opcode
    // Result beats
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0]      m_axis_tdata,   // nearest_index, found,
                                                         // inside_dead_zone, nearest_dist_sq
    // Radius register
    input  wire logic                    i_cfg_we,
    input  wire logic [RAD_BITS-1:0]     i_cfg_wdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    t_state                  r_state;
    logic [CNT_BITS-1:0]     r_scan;       // sweep / scan pointer, can reach the depth
    logic [CNT_BITS-1:0]     r_in_use;     // one past the highest slot written
    logic                    r_rd_vld;
    logic [IDX_BITS-1:0]     r_rd_idx;
    logic [COORD_BITS-1:0]   r_qx;
    logic [COORD_BITS-1:0]   r_qy;
    logic                    r_m_valid;
    logic [M_TDATA_BITS-1:0] r_m_data;
    logic [RAD_BITS-1:0]     r_radius;
    logic [R2_BITS-1:0]      r_r2;

    // input beat fields
    logic                    s_acc;
    t_opcode                 s_op;
    logic [ENTRY_BITS-1:0]   s_idx;
    logic [COORD_BITS-1:0]   s_x;
    logic [COORD_BITS-1:0]   s_y;
    logic                    s_alive;
    logic                    wr_ok;
    logic [CNT_BITS-1:0]     idx_p1;

    // table ports
    logic                    mem_we;
    logic [IDX_BITS-1:0]     mem_waddr;
    t_node                   mem_wdata;
    t_node                   mem_rdata;
    logic                    issue;

    t_scan                   dist_in;
    t_best                   best;
    logic                    dist_busy;
    logic                    in_zone;
    logic                    m_load;       // result goes into the output register

    always_comb begin
        s_acc   = s_axis_tvalid && s_axis_tready;
        s_op    = t_opcode'(s_axis_tuser);
        s_idx   = s_axis_tdata[S_IDX_LSB +: ENTRY_BITS];
        s_x     = s_axis_tdata[S_X_LSB +: COORD_BITS];
        s_y     = s_axis_tdata[S_Y_LSB +: COORD_BITS];
        s_alive = s_axis_tdata[S_ALIVE_BIT];
        // slots past the table are dropped
        wr_ok   = CNT_BITS'(s_idx) < CNT_BITS'(MAX_NODES);
        idx_p1  = CNT_BITS'(s_idx) + CNT_BITS'(1);
        issue   = (r_state == ST_SCAN) && (r_scan < r_in_use);

        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_scan[IDX_BITS-1:0];
            mem_wdata = '0;
        end else begin
            mem_we          = s_acc && (s_op == OP_WRITE) && wr_ok;
            mem_waddr       = s_idx[IDX_BITS-1:0];
            mem_wdata.alive = s_alive;
            mem_wdata.y     = s_y;
            mem_wdata.x     = s_x;
        end

        dist_in.vld  = r_rd_vld;
        dist_in.idx  = r_rd_idx;
        dist_in.node = mem_rdata;

        in_zone = best.found && (best.dist_sq < DIST_BITS'(r_r2));
        m_load  = (r_state == ST_RESULT) && (!r_m_valid || m_axis_tready);
    end

    nlns_node_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_scan[IDX_BITS-1:0]),
        .o_rdata (mem_rdata)
    );

    nlns_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_acc && (s_op == OP_QUERY)),
        .i_scan  (dist_in),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_best  (best),
        .o_busy  (dist_busy)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_scan    <= '0;
            r_in_use  <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            r_rd_idx <= r_scan[IDX_BITS-1:0];
            if (m_load) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {{M_PAD_BITS{1'b0}}, best.dist_sq, in_zone, best.found,
                              ENTRY_BITS'(best.idx)};
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    // zero sweep so every slot reads as dead
                    if (r_scan[IDX_BITS-1:0] == IDX_BITS'(MAX_NODES - 1)) begin
                        r_scan  <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_scan <= r_scan + CNT_BITS'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_op == OP_QUERY) begin
                            r_qx    <= s_x;
                            r_qy    <= s_y;
                            r_scan  <= '0;
                            r_state <= ST_SCAN;
                        end else if (wr_ok && (idx_p1 > r_in_use)) begin
                            r_in_use <= idx_p1;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_scan < r_in_use) begin
                        r_scan <= r_scan + CNT_BITS'(1);
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_rd_vld && !dist_busy) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (m_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Radius register; its square is kept ready for the final compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= R2_BITS'(r_radius) * R2_BITS'(r_radius);
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

@@ design/nlns_checker.sv @@
// Port-level checker for nearest_live_node_search, bound to the top level.
// Depends on nlns_pkg and nearest_live_node_search_macros.svh.
`default_nettype none
`include "nearest_live_node_search_macros.svh"

module nlns_checker
    import nlns_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    s_axis_tvalid,
    input wire logic                    s_axis_tready,
    input wire logic [0:0]              s_axis_tuser,
    input wire logic                    m_axis_tvalid,
    input wire logic                    m_axis_tready,
    input wire logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    // stalled result beat holds
    `NLNS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped or changed while stalled")

    // a query occupies the block, so no beat is taken right after it
    `NLNS_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY), !s_axis_tready, "input ready right after a query")

    // no live entry: every result field is zero
    `NLNS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[M_FOUND_BIT], (m_axis_tdata[M_DIST_MSB:M_DIST_LSB] == '0) && (m_axis_tdata[M_IDX_LSB +: ENTRY_BITS] == '0) && !m_axis_tdata[M_INSIDE_BIT], "nonzero fields without a match")

    // dead zone only with a match, padding always zero
    `NLNS_ASSERT_IMP(a_zone_found, i_clk, i_rst_n, m_axis_tvalid, (!m_axis_tdata[M_INSIDE_BIT] || m_axis_tdata[M_FOUND_BIT]) && (m_axis_tdata[M_TDATA_BITS-1:M_USED_BITS] == '0), "dead zone without match or padding set")

endmodule

bind nearest_live_node_search nlns_checker u_nlns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
